// ----- rtl/core/easing_curve_evaluator_top_assert.svh -----
// ----------------------------------------------------------------------------
// easing curve evaluator assertion macros
// concurrent check forms used by the evaluator's queue module
// ----------------------------------------------------------------------------
`ifndef EASING_CURVE_EVALUATOR_TOP_ASSERT_SVH
`define EASING_CURVE_EVALUATOR_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define ECE_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("ece: invariant violated");

// consequence holds in the same cycle as the antecedent
`define ECE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ece: same-cycle check failed");

// consequence holds in the cycle after the antecedent
`define ECE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ece: next-cycle check failed");

`endif

// ----- rtl/core/ece_pkg.sv -----
// ----------------------------------------------------------------------------
// ece_pkg
// shared types and codes of the easing curve evaluator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ece_pkg;

	// input curve codes that the block supports
	localparam logic [3:0] ACT_LINEAR = 4'd0;
	localparam logic [3:0] ACT_QUAD   = 4'd1;
	localparam logic [3:0] ACT_BOUNCE = 4'd9;

	// ease modes, any other code is in-out
	localparam logic [1:0] MODE_IN  = 2'd0;
	localparam logic [1:0] MODE_OUT = 2'd1;

	typedef enum logic [1:0] {
		CRV_LIN,
		CRV_QUAD,
		CRV_BOUNCE
	} crv_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_UNSUP    = 2'd1,
		ST_ZERO_DUR = 2'd2
	} status_t;

	// bounce segments, by 11p against 4, 8, 10
	typedef enum logic [1:0] {
		SEG_0,
		SEG_1,
		SEG_2,
		SEG_3
	} seg_t;

	// classification carried with each item from front to back
	typedef struct packed {
		crv_t       crv;
		logic [1:0] mode;
		status_t    status;
	} ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/ece_front.sv -----
// ----------------------------------------------------------------------------
// ece_front
// classifies a request and forms the divider's starting remainder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ece_front #(
	parameter int TIME_BITS = 16,
	parameter int FRAC_BITS = 16
) (
	input  wire logic [3:0]           action,
	input  wire logic [1:0]           ease_mode,
	input  wire logic [TIME_BITS-1:0] elapsed,
	input  wire logic [TIME_BITS-1:0] duration,
	output ece_pkg::ctl_t             ctl,
	output logic [TIME_BITS-1:0]      rem0,
	output logic [FRAC_BITS:0]        nq0
);
	import ece_pkg::*;

	localparam int T = TIME_BITS;
	localparam int F = FRAC_BITS;

	logic [T-1:0] t_sat;
	logic [T+F:0] num;
	logic         unsup;
	crv_t         crv;

	// curve decode
	always_comb begin
		unsup = 1'b0;
		unique case (action)
			ACT_LINEAR: crv = CRV_LIN;
			ACT_QUAD:   crv = CRV_QUAD;
			ACT_BOUNCE: crv = CRV_BOUNCE;
			default: begin
				crv   = CRV_LIN;
				unsup = 1'b1;
			end
		endcase
	end

	// status, unsupported curve wins over zero duration
	always_comb begin
		ctl.crv  = crv;
		ctl.mode = ease_mode;
		if (unsup)
			ctl.status = ST_UNSUP;
		else if (duration == '0)
			ctl.status = ST_ZERO_DUR;
		else
			ctl.status = ST_OK;
	end

	// numerator t*2^F + d/2, the top bits are below d
	always_comb begin
		t_sat = (elapsed > duration) ? duration : elapsed;
		num   = ({{(F+1){1'b0}}, t_sat} << F) + {{(F+2){1'b0}}, duration[T-1:1]};
		rem0  = num[T+F:F+1];
		nq0   = num[F:0];
	end

endmodule

`default_nettype wire

// ----- rtl/core/ece_queue.sv -----
// ----------------------------------------------------------------------------
// ece_queue
// short first-in first-out queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "easing_curve_evaluator_top_assert.svh"

module ece_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_valid,
	output logic                  wr_ready,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  rd_valid,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data
);
	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      cnt_q;
	logic             push;
	logic             pop;

	assign wr_ready = (cnt_q != (AW+1)'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_en && rd_valid;
	assign rd_data  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// checks
	`ECE_ASSERT_ALWAYS(a_cnt_max, clk, arst_n, cnt_q <= (AW+1)'(DEPTH))
	`ECE_ASSERT_NEXT(a_cnt_up, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1)
	`ECE_ASSERT_NEXT(a_ptr_gap, clk, arst_n, 1'b1, (wr_ptr_q - rd_ptr_q) == cnt_q[AW-1:0])

endmodule

`default_nettype wire

// ----- rtl/core/ece_back.sv -----
// ----------------------------------------------------------------------------
// ece_back
// divider, easing, scaling and output register of the evaluator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ece_back #(
	parameter int TIME_BITS  = 16,
	parameter int VALUE_BITS = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   q_valid,
	output logic                        q_pop,
	input  wire ece_pkg::ctl_t          q_ctl,
	input  wire logic [VALUE_BITS-1:0]  q_b,
	input  wire logic [VALUE_BITS-1:0]  q_c,
	input  wire logic [TIME_BITS-1:0]   q_d,
	input  wire logic [TIME_BITS-1:0]   q_rem,
	input  wire logic [FRAC_BITS:0]     q_nq,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [VALUE_BITS-1:0]       value,
	output logic [1:0]                  status
);
	import ece_pkg::*;

	localparam int T  = TIME_BITS;
	localparam int V  = VALUE_BITS;
	localparam int F  = FRAC_BITS;
	localparam int DS = F + 1;
	localparam int OW = F + 3;
	localparam int PW = 2 * OW;
	localparam int H  = (V + 1) / 2;

	localparam logic [F+1:0] ONE  = {2'b01, {F{1'b0}}};
	localparam logic [F+1:0] TWO  = {2'b10, {F{1'b0}}};
	localparam logic [F+1:0] HALF = {3'b001, {(F-1){1'b0}}};
	localparam logic [F+1:0] ADD1 = ONE - (ONE >> 2);
	localparam logic [F+1:0] ADD2 = ONE - (ONE >> 4);
	localparam logic [F+1:0] ADD3 = ONE - (ONE >> 6);
	localparam logic [F+5:0] LIM4 = (F+6)'(4) << F;
	localparam logic [F+5:0] LIM8 = (F+6)'(8) << F;
	localparam logic [F+5:0] LIM10 = (F+6)'(10) << F;
	localparam logic [F+7:0] K12 = (F+8)'(12) << F;
	localparam logic [F+7:0] K18 = (F+8)'(18) << F;
	localparam logic [F+7:0] K21 = (F+8)'(21) << F;
	localparam logic [PW:0]  RND_Q = (PW+1)'(1) << (F - 1);
	localparam logic [PW:0]  RND_B = (PW+1)'(1) << (F + 5);
	localparam logic [V+F:0] RND_M = (V+F+1)'(1) << (F - 1);
	localparam logic signed [V+1:0] MAXV = {3'b000, {(V-1){1'b1}}};
	localparam logic signed [V+1:0] MINV = {3'b111, {(V-1){1'b0}}};

	// one restoring division step, quotient bit shifts in at the bottom
	function automatic logic [T+F:0] div_step(input logic [T-1:0] rem,
			input logic [F:0] nq, input logic [T-1:0] d);
		logic [T:0] x;
		logic [T:0] diff;
		logic       ge;
		x    = {rem, nq[F]};
		diff = x - {1'b0, d};
		ge   = (x >= {1'b0, d});
		return {ge ? diff[T-1:0] : x[T-1:0], nq[F-1:0], ge};
	endfunction

	logic adv;

	// whole pipe moves when the output register can take an item
	assign adv   = !out_valid || out_ready;
	assign q_pop = adv && q_valid;

	// divider stages
	logic [DS-1:0] dv_vld_q;
	ctl_t          dv_ctl_q [DS];
	logic [V-1:0]  dv_b_q   [DS];
	logic [V-1:0]  dv_c_q   [DS];
	logic [T-1:0]  dv_d_q   [DS];
	logic [T-1:0]  dv_rem_q [DS];
	logic [F:0]    dv_nq_q  [DS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_vld_q <= '0;
		else if (adv)
			dv_vld_q <= {dv_vld_q[DS-2:0], q_valid};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			{dv_rem_q[0], dv_nq_q[0]} <= div_step(q_rem, q_nq, q_d);
			dv_d_q[0]   <= q_d;
			dv_ctl_q[0] <= q_ctl;
			dv_b_q[0]   <= q_b;
			dv_c_q[0]   <= q_c;
			for (int i = 1; i < DS; i++) begin
				{dv_rem_q[i], dv_nq_q[i]} <= div_step(dv_rem_q[i-1], dv_nq_q[i-1],
					dv_d_q[i-1]);
				dv_d_q[i]   <= dv_d_q[i-1];
				dv_ctl_q[i] <= dv_ctl_q[i-1];
				dv_b_q[i]   <= dv_b_q[i-1];
				dv_c_q[i]   <= dv_c_q[i-1];
			end
		end
	end

	// stage 1: pick the multiplier's operands
	logic [F+1:0]   pw;
	logic           p_hi;
	logic [F+1:0]   bx;
	logic [F+5:0]   x11;
	logic [F+7:0]   u_raw;
	logic [F+7:0]   u_abs;
	logic [F+7:0]   k_sel;
	seg_t           seg;
	logic [OW-1:0]  opa;
	logic [OW-1:0]  opb;
	ctl_t           ctl_d;

	assign ctl_d = dv_ctl_q[DS-1];

	always_comb begin
		pw   = {1'b0, dv_nq_q[DS-1]};
		p_hi = (pw >= HALF);
		// bounce argument, every form goes through the ease-out curve
		case (ctl_d.mode)
			MODE_IN:  bx = ONE - pw;
			MODE_OUT: bx = pw;
			default:  bx = p_hi ? ((pw << 1) - ONE) : (ONE - (pw << 1));
		endcase
		x11 = {4'b0000, bx} * (F+6)'(11);
		if (x11 < LIM4) begin
			seg = SEG_0;
			k_sel = '0;
		end else if (x11 < LIM8) begin
			seg = SEG_1;
			k_sel = K12;
		end else if (x11 < LIM10) begin
			seg = SEG_2;
			k_sel = K18;
		end else begin
			seg = SEG_3;
			k_sel = K21;
		end
		u_raw = {1'b0, x11, 1'b0} - k_sel;
		u_abs = u_raw[F+7] ? (~u_raw + 1'b1) : u_raw;
		// operands per curve
		opa = {1'b0, pw};
		opb = {1'b0, ONE};
		unique case (ctl_d.crv)
			CRV_LIN: begin
				opa = {1'b0, pw};
				opb = {1'b0, ONE};
			end
			CRV_QUAD: begin
				case (ctl_d.mode)
					MODE_IN: begin
						opa = {1'b0, pw};
						opb = {1'b0, pw};
					end
					MODE_OUT: begin
						opa = {1'b0, pw};
						opb = {1'b0, TWO - pw};
					end
					default: begin
						if (p_hi) begin
							opa = {1'b0, ONE - pw};
							opb = {1'b0, (ONE - pw) << 1};
						end else begin
							opa = {1'b0, pw};
							opb = {1'b0, pw << 1};
						end
					end
				endcase
			end
			CRV_BOUNCE: begin
				opa = u_abs[OW-1:0];
				opb = u_abs[OW-1:0];
			end
			default: begin
				opa = {1'b0, pw};
				opb = {1'b0, ONE};
			end
		endcase
	end

	logic          vld_s1;
	ctl_t          ctl_s1;
	logic          hi_s1;
	seg_t          seg_s1;
	logic [OW-1:0] opa_s1;
	logic [OW-1:0] opb_s1;
	logic [V-1:0]  b_s1;
	logic [V-1:0]  c_s1;

	// stage 2: product
	logic          vld_s2;
	ctl_t          ctl_s2;
	logic          hi_s2;
	seg_t          seg_s2;
	logic [PW-1:0] prod_s2;
	logic [V-1:0]  b_s2;
	logic [V-1:0]  c_s2;

	// stage 3: rounding and curve form
	logic [PW:0]   sq;
	logic [PW:0]   sb;
	logic [F+1:0]  rq;
	logic [F+1:0]  rb;
	logic [F+1:0]  add_sel;
	logic [F+1:0]  o_sum;
	logic [F+1:0]  o_cl;
	logic [F+1:0]  e_d;

	always_comb begin
		sq = ({1'b0, prod_s2} + RND_Q) >> F;
		sb = ({1'b0, prod_s2} + RND_B) >> (F + 6);
		rq = sq[F+1:0];
		rb = sb[F+1:0];
		unique case (seg_s2)
			SEG_0:   add_sel = '0;
			SEG_1:   add_sel = ADD1;
			SEG_2:   add_sel = ADD2;
			SEG_3:   add_sel = ADD3;
			default: add_sel = '0;
		endcase
		o_sum = rb + add_sel;
		o_cl  = (o_sum > ONE) ? ONE : o_sum;
		unique case (ctl_s2.crv)
			CRV_QUAD: begin
				if (ctl_s2.mode != MODE_IN && ctl_s2.mode != MODE_OUT && hi_s2)
					e_d = ONE - rq;
				else
					e_d = rq;
			end
			CRV_BOUNCE: begin
				case (ctl_s2.mode)
					MODE_IN:  e_d = ONE - o_cl;
					MODE_OUT: e_d = o_cl;
					default:  e_d = hi_s2 ? (((o_cl + 1'b1) >> 1) + HALF)
						: ((ONE - o_cl + 1'b1) >> 1);
				endcase
			end
			default: e_d = rq;
		endcase
	end

	logic         vld_s3;
	ctl_t         ctl_s3;
	logic [F:0]   e_s3;
	logic [V-1:0] b_s3;
	logic [V-1:0] c_s3;

	// stage 4: |c| times eased progress, split in two halves
	logic [V-1:0] ac;

	assign ac = c_s3[V-1] ? (~c_s3 + 1'b1) : c_s3;

	logic             vld_s4;
	ctl_t             ctl_s4;
	logic             neg_s4;
	logic [H+F:0]     plo_s4;
	logic [V-H+F:0]   phi_s4;
	logic [V-1:0]     b_s4;

	// stage 5: join halves and round
	logic [V+F:0] full;
	logic [V+F:0] full_r;

	always_comb begin
		full   = ({{H{1'b0}}, phi_s4} << H) + {{(V-H){1'b0}}, plo_s4};
		full_r = full + RND_M;
	end

	logic         vld_s5;
	ctl_t         ctl_s5;
	logic         neg_s5;
	logic [V:0]   mag_s5;
	logic [V-1:0] b_s5;

	// output: add to start value and saturate, or give zero or the start value by status
	logic signed [V+1:0] bsx;
	logic signed [V+1:0] msx;
	logic signed [V+1:0] vsum;
	logic [V-1:0]        vsat;
	logic [V-1:0]        v_out;

	always_comb begin
		bsx  = {{2{b_s5[V-1]}}, b_s5};
		msx  = {1'b0, mag_s5};
		vsum = neg_s5 ? (bsx - msx) : (bsx + msx);
		if (vsum > MAXV)
			vsat = MAXV[V-1:0];
		else if (vsum < MINV)
			vsat = MINV[V-1:0];
		else
			vsat = vsum[V-1:0];
		unique case (ctl_s5.status)
			ST_UNSUP:    v_out = '0;
			ST_ZERO_DUR: v_out = b_s5;
			default:     v_out = vsat;
		endcase
	end

	logic         out_valid_q;
	logic [V-1:0] value_q;
	status_t      status_q;

	// valid bits of the stages after the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= dv_vld_q[DS-1];
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			vld_s5      <= vld_s4;
			out_valid_q <= vld_s5;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1   <= ctl_d;
			hi_s1    <= p_hi;
			seg_s1   <= seg;
			opa_s1   <= opa;
			opb_s1   <= opb;
			b_s1     <= dv_b_q[DS-1];
			c_s1     <= dv_c_q[DS-1];

			ctl_s2   <= ctl_s1;
			hi_s2    <= hi_s1;
			seg_s2   <= seg_s1;
			prod_s2  <= opa_s1 * opb_s1;
			b_s2     <= b_s1;
			c_s2     <= c_s1;

			ctl_s3   <= ctl_s2;
			e_s3     <= e_d[F:0];
			b_s3     <= b_s2;
			c_s3     <= c_s2;

			ctl_s4   <= ctl_s3;
			neg_s4   <= c_s3[V-1];
			plo_s4   <= {{(F+1){1'b0}}, ac[H-1:0]} * {{H{1'b0}}, e_s3};
			phi_s4   <= {{(F+1){1'b0}}, ac[V-1:H]} * {{(V-H){1'b0}}, e_s3};
			b_s4     <= b_s3;

			ctl_s5   <= ctl_s4;
			neg_s5   <= neg_s4;
			mag_s5   <= full_r[V+F:F];
			b_s5     <= b_s4;

			value_q  <= v_out;
			status_q <= ctl_s5.status;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

endmodule

`default_nettype wire

// ----- rtl/core/easing_curve_evaluator_top.sv -----
// ----------------------------------------------------------------------------
// easing_curve_evaluator_top
// evaluates linear, quadratic and bounce easing curves per request
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  request  | in_valid / in_ready  | action ease_mode elapsed start_value
//           |                      | change duration
//  result   | out_valid/ out_ready | value status
//
// one item per cycle sustained while the output is not stalled; a result is
// registered in turn by the queue, the one-bit-per-stage progress divider,
// the arithmetic stages and the output register
// a four-entry queue sits between the classifier and the arithmetic pipe
// the arithmetic pipe holds as a whole while a result waits at the output
// reset clears the queue and every valid bit, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module easing_curve_evaluator_top #(
	parameter int TIME_BITS  = 16,
	parameter int VALUE_BITS = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [3:0]                   action,
	input  wire logic [1:0]                   ease_mode,
	input  wire logic [TIME_BITS-1:0]         elapsed,
	input  wire logic signed [VALUE_BITS-1:0] start_value,
	input  wire logic signed [VALUE_BITS-1:0] change,
	input  wire logic [TIME_BITS-1:0]         duration,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [VALUE_BITS-1:0]      value,
	output logic [1:0]                        status
);
	import ece_pkg::*;

	localparam int T  = TIME_BITS;
	localparam int V  = VALUE_BITS;
	localparam int F  = FRAC_BITS;
	localparam int CW = $bits(ctl_t);
	localparam int QW = CW + 2 * V + 2 * T + F + 1;

	ctl_t          f_ctl;
	logic [T-1:0]  f_rem;
	logic [F:0]    f_nq;
	logic [QW-1:0] wr_data;
	logic [QW-1:0] rd_data;
	logic          q_valid;
	logic          q_pop;
	ctl_t          q_ctl;
	logic [V-1:0]  q_b;
	logic [V-1:0]  q_c;
	logic [T-1:0]  q_d;
	logic [T-1:0]  q_rem;
	logic [F:0]    q_nq;
	logic [V-1:0]  value_u;

	// classify
	ece_front #(
		.TIME_BITS(T),
		.FRAC_BITS(F)
	) u_front (
		.action   (action),
		.ease_mode(ease_mode),
		.elapsed  (elapsed),
		.duration (duration),
		.ctl      (f_ctl),
		.rem0     (f_rem),
		.nq0      (f_nq)
	);

	// queue between front and back
	assign wr_data = {f_ctl, start_value, change, duration, f_rem, f_nq};

	ece_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(in_valid),
		.wr_ready(in_ready),
		.wr_data (wr_data),
		.rd_valid(q_valid),
		.rd_en   (q_pop),
		.rd_data (rd_data)
	);

	assign {q_ctl, q_b, q_c, q_d, q_rem, q_nq} = rd_data;

	// arithmetic pipe
	ece_back #(
		.TIME_BITS (T),
		.VALUE_BITS(V),
		.FRAC_BITS (F)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_ctl    (q_ctl),
		.q_b      (q_b),
		.q_c      (q_c),
		.q_d      (q_d),
		.q_rem    (q_rem),
		.q_nq     (q_nq),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value    (value_u),
		.status   (status)
	);

	assign value = value_u;

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// checks the easing curve evaluator against a predictor of its fixed-point
// arithmetic, over directed corner items and random traffic with idling and output stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import ece_pkg::*;

	localparam longint ONE_Q  = 64'd1 << 16;
	localparam longint HALF_Q = 64'd1 << 15;
	localparam int     LATENCY = 24;
	localparam longint CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [31:0] val;
		logic [1:0]  st;
	} eased_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [3:0] action = '0;
	logic [1:0] ease_mode = '0;
	logic [15:0] elapsed = '0;
	logic signed [31:0] start_value = '0;
	logic signed [31:0] change = '0;
	logic [15:0] duration = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] value;
	logic [1:0] status;

	eased_t pending_q[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;
	longint cycles = 0;

	easing_curve_evaluator_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .ease_mode(ease_mode), .elapsed(elapsed),
		.start_value(start_value), .change(change), .duration(duration),
		.out_valid(out_valid), .out_ready(out_ready),
		.value(value), .status(status)
	);

	always #5 clk = ~clk;

	// round half up shift
	function automatic longint rshift(longint v, int sh);
		return (v + (64'd1 << (sh - 1))) >>> sh;
	endfunction

	function automatic longint bounce_out_q(longint p);
		longint p11, k, add, u, e;
		p11 = p * 11;
		if (p11 < 4 * ONE_Q) begin k = 0; add = 0; end
		else if (p11 < 8 * ONE_Q) begin k = 12; add = (ONE_Q * 3) >> 2; end
		else if (p11 < 10 * ONE_Q) begin k = 18; add = (ONE_Q * 15) >> 4; end
		else begin k = 21; add = (ONE_Q * 63) >> 6; end
		u = 22 * p - k * ONE_Q;
		if (u < 0) u = -u;
		e = rshift(u * u, 22) + add;
		return (e > ONE_Q) ? ONE_Q : e;
	endfunction

	function automatic longint bounce_in_q(longint p);
		return ONE_Q - bounce_out_q(ONE_Q - p);
	endfunction

	// eased progress for one curve and mode
	function automatic longint ease_q(logic [3:0] crv, logic [1:0] md, longint p);
		longint q;
		if (crv == ACT_LINEAR) return p;
		if (crv == ACT_QUAD) begin
			if (md == MODE_IN) return rshift(p * p, 16);
			if (md == MODE_OUT) return rshift(p * (2 * ONE_Q - p), 16);
			if (p < HALF_Q) return rshift(2 * p * p, 16);
			q = ONE_Q - p;
			return ONE_Q - rshift(2 * q * q, 16);
		end
		if (md == MODE_IN) return bounce_in_q(p);
		if (md == MODE_OUT) return bounce_out_q(p);
		if (p < HALF_Q) return (bounce_in_q(2 * p) + 1) >> 1;
		return ((bounce_out_q(2 * p - ONE_Q) + 1) >> 1) + HALF_Q;
	endfunction

	function automatic eased_t predict_value(logic [3:0] crv, logic [1:0] md,
			logic [15:0] t_in, logic signed [31:0] b, logic signed [31:0] c,
			logic [15:0] d);
		eased_t r;
		longint t, dd, p, e, ac, m, v;
		if (crv != ACT_LINEAR && crv != ACT_QUAD && crv != ACT_BOUNCE) begin
			r.val = '0;
			r.st = ST_UNSUP;
		end else if (d == 0) begin
			r.val = b;
			r.st = ST_ZERO_DUR;
		end else begin
			t = t_in;
			dd = d;
			if (t > dd) t = dd;
			p = ((t << 16) + (dd >> 1)) / dd;
			if (p > ONE_Q) p = ONE_Q;
			e = ease_q(crv, md, p);
			ac = (c < 0) ? -longint'(c) : longint'(c);
			m = (((ac >> 24) * e) << 8) + rshift((ac & 64'hFFFFFF) * e, 16);
			v = (c < 0) ? longint'(b) - m : longint'(b) + m;
			if (v > 64'sd2147483647) v = 64'sd2147483647;
			if (v < -64'sd2147483648) v = -64'sd2147483648;
			r.val = v[31:0];
			r.st = ST_OK;
		end
		return r;
	endfunction

	// send one item and log its expected result
	task automatic send_item(logic [3:0] a, logic [1:0] md, logic [15:0] t,
			logic [31:0] b, logic [31:0] c, logic [15:0] d);
		bit idle;
		idle = (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct);
		if (idle)
			in_valid <= 1'b0;
		while (idle) begin
			@(posedge clk);
			idle = ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		action <= a;
		ease_mode <= md;
		elapsed <= t;
		start_value <= b;
		change <= c;
		duration <= d;
		pending_q.push_back(predict_value(a, md, t, b, c, d));
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
	endtask

	// receiver readiness
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
	end

	// result checker
	always @(posedge clk) begin
		eased_t x;
		cycles <= cycles + 1;
		if (out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				$error("unexpected item: value %0d status %0d", value, status);
				errors++;
			end else begin
				x = pending_q.pop_front();
				if (value !== x.val) begin
					$error("value expected %0d actual %0d", $signed(x.val), value);
					errors++;
				end
				if (status !== x.st) begin
					$error("status expected %0d actual %0d", x.st, status);
					errors++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic [3:0] pick_action();
		int r;
		r = $urandom_range(9);
		if (r < 3) return ACT_LINEAR;
		if (r < 6) return ACT_QUAD;
		if (r < 9) return ACT_BOUNCE;
		return 4'($urandom);
	endfunction

	task automatic send_random();
		logic [15:0] d, t;
		logic [31:0] b, c;
		d = ($urandom_range(9) == 0) ? 16'($urandom_range(3)) : 16'($urandom);
		t = ($urandom_range(5) == 0) ? 16'($urandom) : 16'($urandom_range(d));
		b = $urandom_range(3) == 0 ? $urandom : 32'($signed($urandom_range(2000)) - 1000);
		c = $urandom;
		send_item(pick_action(), 2'($urandom), t, b, c, d);
	endtask

	task automatic test_directed();
		send_item(ACT_LINEAR, MODE_IN, 16'd0, 32'd100, 32'd1000, 16'd10);
		send_item(ACT_LINEAR, MODE_OUT, 16'd5, 32'd0, 32'd1000, 16'd10);
		send_item(ACT_LINEAR, 2'd2, 16'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF);
		send_item(ACT_LINEAR, MODE_IN, 16'hFFFF, 32'h80000000, 32'h80000000, 16'd1);
		send_item(ACT_QUAD, MODE_IN, 16'd3, 32'd0, 32'h7FFFFFFF, 16'd7);
		send_item(ACT_QUAD, MODE_OUT, 16'd3, 32'd0, 32'h80000000, 16'd7);
		send_item(ACT_QUAD, 2'd2, 16'd2, 32'd50, 32'd1000000, 16'd7);
		send_item(ACT_QUAD, 2'd2, 16'd5, 32'd50, 32'd1000000, 16'd7);
		send_item(ACT_QUAD, 2'd3, 16'd5, 32'hFFFFFFFF, 32'd12345, 16'd9);
		send_item(ACT_BOUNCE, MODE_IN, 16'd30, 32'd0, 32'd65536, 16'd100);
		send_item(ACT_BOUNCE, MODE_OUT, 16'd30, 32'd0, 32'd65536, 16'd100);
		send_item(ACT_BOUNCE, MODE_OUT, 16'd80, 32'd0, 32'd65536, 16'd100);
		send_item(ACT_BOUNCE, MODE_OUT, 16'd95, 32'd0, 32'd65536, 16'd100);
		send_item(ACT_BOUNCE, 2'd2, 16'd20, 32'd0, 32'h7FFFFFFF, 16'd100);
		send_item(ACT_BOUNCE, 2'd3, 16'd70, 32'd0, 32'h80000001, 16'd100);
		send_item(ACT_BOUNCE, MODE_IN, 16'hFFFF, 32'd0, 32'd1, 16'hFFFF);
		send_item(4'd2, MODE_IN, 16'd1, 32'd5, 32'd5, 16'd0);
		send_item(4'd8, MODE_OUT, 16'd1, 32'd5, 32'd5, 16'd2);
		send_item(4'd10, 2'd2, 16'd1, 32'd5, 32'd5, 16'd2);
		send_item(4'd15, 2'd3, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
		send_item(ACT_QUAD, MODE_IN, 16'd9, 32'h80000000, 32'd1, 16'd0);
		send_item(ACT_BOUNCE, MODE_OUT, 16'd9, 32'h7FFFFFFF, 32'd1, 16'd0);
		send_item(ACT_LINEAR, MODE_OUT, 16'd200, 32'h7FFFFFF0, 32'd100, 16'd50);
		drain();
	endtask

	task automatic test_phase(int idle, int stall, int n);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (n) send_random();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();
	endtask

	// long output hold-off while the sender keeps offering items
	task automatic test_backpressure();
		hold_off = 200;
		repeat (60) send_random();
		drain();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_phase(0, 0, 350);
		test_phase(61, 0, 350);
		test_phase(0, 61, 350);
		test_phase(11, 11, 340);
		test_backpressure();
		repeat (LATENCY * 2) @(posedge clk);
		if (errors == 0 && pending_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
